// ===== rtl/ldp_pkg.sv =====
package ldp_pkg;

  localparam int NUM_PRIMS_DEF  = 256;
  localparam int MAX_LEN_DEF    = 10;
  localparam int COUNT_BITS_DEF = 20;

  localparam int KIND_W    = 2;
  localparam int ENTRY_W   = 8;
  localparam int SLOT_W    = 4;
  localparam int SYM_W     = 8;
  localparam int WLEN_W    = 4;
  localparam int LONGEST_W = 20;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_SYM  = 2'd0,
    KIND_WR_LEN  = 2'd1,
    KIND_SEQ     = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_len;
    logic wr_sym;
    logic wr_len;
    logic seq_shift;
    logic seq_clear;
    logic rd_en;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/longest_dictionary_prefix_core.sv =====
// Table writes and restart: the table write or restart takes effect on accept, and the
// result is registered from ST_RESP. Sequence symbol: ST_SCAN, ST_DRAIN, ST_COMMIT, then
// ST_RESP registers the result; the scan reads one dictionary entry per cycle.
// One item in flight; the next is taken once its result sits in the output register.
// Reset (rst_n, synchronous, active low) clears the sequence state and starts a pass
// over all NUM_PRIMS entries that zeroes every word length; no input is taken meanwhile.
module longest_dictionary_prefix_core #(
  parameter int NUM_PRIMS  = ldp_pkg::NUM_PRIMS_DEF,
  parameter int MAX_LEN    = ldp_pkg::MAX_LEN_DEF,
  parameter int COUNT_BITS = ldp_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ldp_pkg::KIND_W-1:0]    in_kind,
  input  logic [ldp_pkg::ENTRY_W-1:0]   in_entry,
  input  logic [ldp_pkg::SLOT_W-1:0]    in_slot,
  input  logic [ldp_pkg::SYM_W-1:0]     in_symbol,
  input  logic [ldp_pkg::WLEN_W-1:0]    in_word_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ldp_pkg::LONGEST_W-1:0] out_longest,
  output logic                          out_reached,
  output logic                          out_stuck
);
  import ldp_pkg::*;

  localparam int AW = (NUM_PRIMS > 1) ? $clog2(NUM_PRIMS) : 1;

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [AW-1:0] addr;

  ldp_ctrl #(
    .NUM_PRIMS (NUM_PRIMS),
    .AW        (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .status   (status),
    .cmd      (cmd),
    .addr     (addr)
  );

  ldp_datapath #(
    .NUM_PRIMS  (NUM_PRIMS),
    .MAX_LEN    (MAX_LEN),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .addr           (addr),
    .in_entry       (in_entry),
    .in_slot        (in_slot),
    .in_symbol      (in_symbol),
    .in_word_length (in_word_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_longest    (out_longest),
    .out_reached    (out_reached),
    .out_stuck      (out_stuck)
  );

endmodule

// ===== rtl/ldp_ctrl.sv =====
module ldp_ctrl #(
  parameter int NUM_PRIMS = ldp_pkg::NUM_PRIMS_DEF,
  parameter int AW        = (NUM_PRIMS > 1) ? $clog2(NUM_PRIMS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ldp_pkg::KIND_W-1:0] in_kind,
  input  ldp_pkg::dp_status_t        status,
  output ldp_pkg::dp_cmd_t           cmd,
  output logic [AW-1:0]              addr
);
  import ldp_pkg::*;

  localparam logic [AW:0] LAST_ENTRY = (AW+1)'(NUM_PRIMS - 1);

  state_t        state_r, state_nxt;
  logic [AW:0]   ctr_r, ctr_nxt;
  logic          accept;
  logic          ctr_last;
  kind_t         kind;

  assign kind     = kind_t'(in_kind);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign ctr_last = (ctr_r == LAST_ENTRY);
  assign addr     = ctr_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (ctr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_nxt = (kind == KIND_SEQ) ? ST_SCAN : ST_RESP;
      end
      ST_SCAN:   if (ctr_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!status.pipe_busy) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_RESP;
      ST_RESP:   if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    ctr_nxt = ctr_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_len = 1'b1;
        ctr_nxt     = ctr_r + 1'b1;
      end
      ST_IDLE: begin
        ctr_nxt = '0;
        if (accept) begin
          unique case (kind)
            KIND_WR_SYM:  cmd.wr_sym    = 1'b1;
            KIND_WR_LEN:  cmd.wr_len    = 1'b1;
            KIND_SEQ:     cmd.seq_shift = 1'b1;
            KIND_RESTART: cmd.seq_clear = 1'b1;
            default:      cmd.seq_clear = 1'b0;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        ctr_nxt   = ctr_r + 1'b1;
      end
      ST_DRAIN:  cmd = '0;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_RESP:   cmd.load_out = status.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ctr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

endmodule

// ===== rtl/ldp_datapath.sv =====
module ldp_datapath #(
  parameter int NUM_PRIMS  = ldp_pkg::NUM_PRIMS_DEF,
  parameter int MAX_LEN    = ldp_pkg::MAX_LEN_DEF,
  parameter int COUNT_BITS = ldp_pkg::COUNT_BITS_DEF,
  parameter int AW         = (NUM_PRIMS > 1) ? $clog2(NUM_PRIMS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ldp_pkg::dp_cmd_t              cmd,
  output ldp_pkg::dp_status_t           status,
  input  logic [AW-1:0]                 addr,
  input  logic [ldp_pkg::ENTRY_W-1:0]   in_entry,
  input  logic [ldp_pkg::SLOT_W-1:0]    in_slot,
  input  logic [ldp_pkg::SYM_W-1:0]     in_symbol,
  input  logic [ldp_pkg::WLEN_W-1:0]    in_word_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ldp_pkg::LONGEST_W-1:0] out_longest,
  output logic                          out_reached,
  output logic                          out_stuck
);
  import ldp_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int RI_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Symbols are stored reversed: lane MAX_LEN-1-slot, so a right shift aligns a word.
  logic [MAX_LEN-1:0][SYM_W-1:0] sym_mem [NUM_PRIMS];
  logic [LEN_W-1:0]              len_mem [NUM_PRIMS];

  logic [MAX_LEN-1:0][SYM_W-1:0] rd_row_r;
  logic [LEN_W-1:0]              rd_len_r;
  logic                          rd_vld_r;

  logic [MAX_LEN-1:0]            cmp_eq_r;
  logic                          cmp_ok_r;
  logic                          cmp_vld_r;
  logic                          hit_r;

  logic [MAX_LEN-1:0][SYM_W-1:0] recent_r, recent_nxt;
  logic [MAX_LEN:0]              win_r;
  logic [COUNT_BITS-1:0]         pos_r, best_r, pos_nxt;

  logic                          out_vld_r;
  logic [LONGEST_W-1:0]          out_longest_r;
  logic                          out_reached_r;
  logic                          out_stuck_r;

  logic                          entry_ok, slot_ok, wlen_ok;
  logic                          sym_we, len_we;
  logic [AW-1:0]                 wr_addr;
  logic [LEN_W-1:0]              len_wdata;
  logic [RI_W-1:0]               lane;
  logic [MAX_LEN-1:0][SYM_W-1:0] aligned;
  logic [LEN_W-1:0]              shift_bytes;
  logic [MAX_LEN-1:0]            eq;
  logic                          ok;

  assign entry_ok  = (32'(in_entry) < NUM_PRIMS);
  assign slot_ok   = (32'(in_slot) < MAX_LEN);
  assign wlen_ok   = (32'(in_word_length) <= MAX_LEN);
  assign sym_we    = cmd.wr_sym && entry_ok && slot_ok;
  assign len_we    = cmd.clr_len || (cmd.wr_len && entry_ok && wlen_ok);
  assign wr_addr   = cmd.clr_len ? addr : AW'(in_entry);
  assign len_wdata = cmd.clr_len ? '0 : LEN_W'(in_word_length);
  assign lane      = RI_W'(MAX_LEN - 1) - RI_W'(in_slot);

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[wr_addr][lane] <= in_symbol;
    if (len_we) len_mem[wr_addr] <= len_wdata;
    rd_row_r <= sym_mem[addr];
    rd_len_r <= len_mem[addr];
  end

  // Compare stage: align the word to the most recent symbols and check the window.
  always_comb begin
    shift_bytes = LEN_W'(MAX_LEN) - rd_len_r;
    aligned     = rd_row_r >> {shift_bytes, 3'b000};
    for (int k = 0; k < MAX_LEN; k++) begin
      eq[k] = (LEN_W'(k) >= rd_len_r) || (aligned[k] == recent_r[k]);
    end
    ok = (rd_len_r != '0) && win_r[rd_len_r - LEN_W'(1)];
  end

  always_ff @(posedge clk) begin
    cmp_eq_r <= eq;
    cmp_ok_r <= ok;
  end

  always_comb begin
    recent_nxt[0] = in_symbol;
    for (int k = 1; k < MAX_LEN; k++) begin
      recent_nxt[k] = recent_r[k-1];
    end
    pos_nxt = (pos_r == COUNT_MAX) ? pos_r : pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      recent_r  <= '0;
      win_r     <= (MAX_LEN+1)'(1);
      pos_r     <= '0;
      best_r    <= '0;
    end else begin
      rd_vld_r  <= cmd.rd_en;
      cmp_vld_r <= rd_vld_r;
      if (cmd.seq_shift) begin
        recent_r <= recent_nxt;
        hit_r    <= 1'b0;
      end else if (cmp_vld_r && cmp_ok_r && (&cmp_eq_r)) begin
        hit_r <= 1'b1;
      end
      if (cmd.seq_clear) begin
        recent_r <= '0;
        win_r    <= (MAX_LEN+1)'(1);
        pos_r    <= '0;
        best_r   <= '0;
      end else if (cmd.commit) begin
        win_r <= {win_r[MAX_LEN-1:0], hit_r};
        pos_r <= pos_nxt;
        if (hit_r && (pos_nxt > best_r)) best_r <= pos_nxt;
      end
    end
  end

  // Output register: hold until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_longest_r <= LONGEST_W'(best_r);
      out_reached_r <= win_r[0];
      out_stuck_r   <= ~|win_r[MAX_LEN-1:0];
    end
  end

  assign status.pipe_busy = rd_vld_r || cmp_vld_r;
  assign status.out_free  = !out_vld_r || !out_stall;

  assign out_valid   = out_vld_r;
  assign out_longest = out_longest_r;
  assign out_reached = out_reached_r;
  assign out_stuck   = out_stuck_r;

endmodule

// ===== test/tb_longest_dictionary_prefix_core.sv =====
module tb_longest_dictionary_prefix_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ldp_pkg::*;

  localparam int NPRIM        = NUM_PRIMS_DEF;
  localparam int MAXL         = MAX_LEN_DEF;
  localparam int CNTW         = COUNT_BITS_DEF;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = NPRIM + 40;

  typedef struct {
    kind_t               kind;
    logic [ENTRY_W-1:0]  entry;
    logic [SLOT_W-1:0]   slot;
    logic [SYM_W-1:0]    symbol;
    logic [WLEN_W-1:0]   word_length;
  } ldp_item_t;

  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 reached;
    logic                 stuck;
  } prefix_status_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [ENTRY_W-1:0]   in_entry = '0;
  logic [SLOT_W-1:0]    in_slot = '0;
  logic [SYM_W-1:0]     in_symbol = '0;
  logic [WLEN_W-1:0]    in_word_length = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LONGEST_W-1:0] out_longest;
  logic                 out_reached;
  logic                 out_stuck;

  longest_dictionary_prefix_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_entry      (in_entry),
    .in_slot       (in_slot),
    .in_symbol     (in_symbol),
    .in_word_length(in_word_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_longest   (out_longest),
    .out_reached   (out_reached),
    .out_stuck     (out_stuck)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus plan and expected results
  ldp_item_t      stim_q[$];
  prefix_status_t status_q[$];
  ldp_item_t      cur_item;
  int             idle_pct = 0;
  int             stall_pct = 0;
  logic           hold_req = 1'b0;
  logic           hold_seen = 1'b0;
  int             hold_left = 0;

  // generator's view of the dictionary, kept in stream order
  logic [SYM_W-1:0] plan_sym [NPRIM][MAXL];
  int               plan_len [NPRIM];
  logic [SYM_W-1:0] alpha [3];
  int               planned_items = 0;

  // predictor state
  logic [SYM_W-1:0]  dict_sym [NPRIM][MAXL];
  logic [WLEN_W-1:0] dict_len [NPRIM];
  logic [SYM_W-1:0]  recent_sym [MAXL];
  logic [MAXL:0]     reach_bits;
  logic [CNTW-1:0]   seq_pos;
  logic [CNTW-1:0]   best_len;

  int mismatches = 0;
  int accepted = 0;
  int seq_count = 0;
  int restart_count = 0;
  int results_seen = 0;
  int reached_seen = 0;
  int stuck_seen = 0;
  int max_longest = 0;

  function automatic void clear_sequence_state();
    for (int k = 0; k < MAXL; k++) recent_sym[k] = '0;
    reach_bits = (MAXL+1)'(1);
    seq_pos = '0;
    best_len = '0;
  endfunction

  function automatic prefix_status_t predict_prefix(ldp_item_t it);
    prefix_status_t st;
    logic hit;
    logic match;
    int wl;
    hit = 1'b0;
    case (it.kind)
      KIND_WR_SYM: if (it.slot < MAXL) dict_sym[it.entry][it.slot] = it.symbol;
      KIND_WR_LEN: if (it.word_length <= MAXL) dict_len[it.entry] = it.word_length;
      KIND_SEQ: begin
        for (int k = MAXL - 1; k > 0; k--) recent_sym[k] = recent_sym[k-1];
        recent_sym[0] = it.symbol;
        for (int e = 0; e < NPRIM && !hit; e++) begin
          wl = dict_len[e];
          // a word counts only if it starts at a reachable position
          if (wl != 0 && reach_bits[wl-1]) begin
            match = 1'b1;
            for (int m = 0; m < wl; m++)
              if (dict_sym[e][m] != recent_sym[wl-1-m]) match = 1'b0;
            hit = match;
          end
        end
        reach_bits = {reach_bits[MAXL-1:0], hit};
        if (seq_pos != '1) seq_pos++;
        if (hit && seq_pos > best_len) best_len = seq_pos;
      end
      KIND_RESTART: clear_sequence_state();
    endcase
    st.longest = best_len;
    st.reached = reach_bits[0];
    st.stuck   = (reach_bits[MAXL-1:0] == '0);
    return st;
  endfunction

  task automatic push_item(kind_t k, int e, int s, int sy, int wl);
    ldp_item_t it;
    it.kind        = k;
    it.entry       = ENTRY_W'((k == KIND_WR_SYM || k == KIND_WR_LEN) ? e : $urandom_range(255));
    it.slot        = SLOT_W'((k == KIND_WR_SYM) ? s : $urandom_range((1 << SLOT_W) - 1));
    it.symbol      = SYM_W'((k == KIND_WR_SYM || k == KIND_SEQ) ? sy : $urandom_range(255));
    it.word_length = WLEN_W'((k == KIND_WR_LEN) ? wl : $urandom_range((1 << WLEN_W) - 1));
    if (k == KIND_WR_SYM && s < MAXL) plan_sym[e][s] = SYM_W'(sy);
    if (k == KIND_WR_LEN && wl <= MAXL) plan_len[e] = wl;
    stim_q.insert(stim_q.size(), it);
    planned_items++;
  endtask

  // mostly whole dictionary words streamed back to back, with some noise,
  // restarts and table writes, some of them ignored, mixed in
  task automatic gen_random(int n);
    int stop_at;
    int r;
    int e;
    int wl;
    int live[$];
    stop_at = planned_items + n;
    while (planned_items < stop_at) begin
      live.delete();
      for (int i = 0; i < NPRIM; i++) if (plan_len[i] != 0) live.insert(live.size(), i);
      r = $urandom_range(99);
      if (live.size() < 3 || r < 10) begin
        // write every symbol first so a live word never has an unwritten slot
        e  = $urandom_range(NPRIM - 1);
        wl = ($urandom_range(9) < 7) ? $urandom_range(4, 1) : $urandom_range(MAXL, 5);
        for (int m = 0; m < wl; m++) push_item(KIND_WR_SYM, e, m, alpha[$urandom_range(2)], 0);
        push_item(KIND_WR_LEN, e, 0, 0, wl);
      end else if (r < 15) begin
        case ($urandom_range(3))
          0: push_item(KIND_WR_SYM, $urandom_range(NPRIM - 1),
                       $urandom_range((1 << SLOT_W) - 1, MAXL), $urandom_range(255), 0);
          1: push_item(KIND_WR_LEN, $urandom_range(NPRIM - 1), 0, 0,
                       $urandom_range((1 << WLEN_W) - 1, MAXL + 1));
          2: push_item(KIND_WR_LEN, live[$urandom_range(live.size() - 1)], 0, 0, 0);
          default: push_item(KIND_WR_SYM, $urandom_range(NPRIM - 1), $urandom_range(MAXL - 1),
                             $urandom_range(255), 0);
        endcase
      end else if (r < 20) begin
        push_item(KIND_RESTART, 0, 0, 0, 0);
      end else if (r < 27) begin
        push_item(KIND_SEQ, 0, 0,
                  $urandom_range(1) ? $urandom_range(255) : alpha[$urandom_range(2)], 0);
      end else begin
        e = live[$urandom_range(live.size() - 1)];
        for (int m = 0; m < plan_len[e]; m++) push_item(KIND_SEQ, 0, 0, plan_sym[e][m], 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid || status_q.size() != 0) @(negedge clk);
  endtask

  task automatic gen_phase(int idle, int stall, int n);
    @(negedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < 3; i++) alpha[i] = SYM_W'($urandom_range(255));
    gen_random(n);
    wait_drained();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall === 1'b0) begin
        status_q.insert(status_q.size(), predict_prefix(cur_item));
        accepted++;
        if (cur_item.kind == KIND_SEQ) seq_count++;
        if (cur_item.kind == KIND_RESTART) restart_count++;
      end
      if (in_valid && in_stall !== 1'b0) begin
        // hold the stalled transaction
      end else if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_item = stim_q.pop_front();
        in_kind        <= cur_item.kind;
        in_entry       <= cur_item.entry;
        in_slot        <= cur_item.slot;
        in_symbol      <= cur_item.symbol;
        in_word_length <= cur_item.word_length;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    prefix_status_t got;
    prefix_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_longest, out_reached, out_stuck};
      results_seen++;
      if (out_reached === 1'b1) reached_seen++;
      if (out_stuck === 1'b1) stuck_seen++;
      if (out_longest > max_longest) max_longest = out_longest;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: longest %0d reached %0b stuck %0b",
                   $realtime, got.longest, got.reached, got.stuck);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp longest %0d reached %0b stuck %0b, got %0d %0b %0b",
                     $realtime, want.longest, want.reached, want.stuck,
                     got.longest, got.reached, got.stuck);
        end
      end
    end
  end

  initial begin
    for (int e = 0; e < NPRIM; e++) dict_len[e] = '0;
    clear_sequence_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty dictionary, extremes, ignored writes, short-history miss
    push_item(KIND_SEQ, 0, 0, 8'h00, 0);
    push_item(KIND_RESTART, 0, 0, 0, 0);
    push_item(KIND_WR_SYM, 0, 0, 8'hA5, 0);
    push_item(KIND_WR_SYM, 0, 1, 8'h5A, 0);
    push_item(KIND_WR_LEN, 0, 0, 0, 2);
    push_item(KIND_WR_SYM, 255, 0, 8'hFF, 0);
    push_item(KIND_WR_LEN, 255, 0, 0, 1);
    push_item(KIND_WR_SYM, 255, MAXL - 1, 8'h00, 0);
    push_item(KIND_WR_SYM, 7, 15, 8'h3C, 0);
    push_item(KIND_WR_LEN, 7, 0, 0, 15);
    push_item(KIND_SEQ, 0, 0, 8'hA5, 0);
    push_item(KIND_SEQ, 0, 0, 8'h5A, 0);
    push_item(KIND_SEQ, 0, 0, 8'hFF, 0);
    push_item(KIND_SEQ, 0, 0, 8'h11, 0);
    push_item(KIND_WR_LEN, 255, 0, 0, 0);
    push_item(KIND_SEQ, 0, 0, 8'hFF, 0);
    push_item(KIND_RESTART, 0, 0, 0, 0);
    push_item(KIND_SEQ, 0, 0, 8'hFF, 0);
    push_item(KIND_SEQ, 0, 0, 8'hA5, 0);
    push_item(KIND_SEQ, 0, 0, 8'h5A, 0);
    wait_drained();

    gen_phase(0, 0, 380);
    // hold off the receiver while transactions keep coming
    hold_req = ~hold_req;
    gen_random(40);
    wait_drained();
    gen_phase(54, 0, 370);
    gen_phase(0, 54, 370);
    gen_phase(35, 35, 370);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d transactions: %0d sequence symbols, %0d restarts, rest table writes",
             accepted, seq_count, restart_count);
    $display("Checked %0d results: %0d reachable, %0d stuck, longest prefix %0d",
             results_seen, reached_seen, stuck_seen, max_longest);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
